>>> hdl/vector_normalize_with_magnitude_core_macros.svh
// Assertion helpers shared by the RTL.
`ifndef VECTOR_NORMALIZE_WITH_MAGNITUDE_CORE_MACROS_SVH
`define VECTOR_NORMALIZE_WITH_MAGNITUDE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VNM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vnm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VNM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vnm assertion failed");

`endif

>>> hdl/vnm_pkg.sv
`timescale 1ns / 1ps
package vnm_pkg;
   localparam int FRAC_BITS  = 16;
   localparam int COMP_WIDTH = 24;
   localparam int SUM_W      = 2 * COMP_WIDTH + 2;
   localparam int ROOT_STEPS = SUM_W / 2;
   localparam int QUOT_W     = FRAC_BITS + 1;
   localparam int REM_W      = COMP_WIDTH + FRAC_BITS + 1;
   localparam int MAG_W      = COMP_WIDTH + 1;
   localparam int FRONT_LAT  = 3;
   localparam int LATENCY    = FRONT_LAT + ROOT_STEPS + QUOT_W + 1;

   localparam logic [COMP_WIDTH-1:0] ONE_SIGNED = (FRAC_BITS <= COMP_WIDTH - 2) ?
      (COMP_WIDTH'(1) << FRAC_BITS) : {1'b0, {(COMP_WIDTH-1){1'b1}}};
   localparam logic [COMP_WIDTH-1:0] ONE_LEN = (FRAC_BITS <= COMP_WIDTH - 1) ?
      (COMP_WIDTH'(1) << FRAC_BITS) : {COMP_WIDTH{1'b1}};

   typedef struct packed {
      logic                  planar;
      logic                  zero;
      logic                  neg_x;
      logic                  neg_y;
      logic                  neg_z;
      logic [COMP_WIDTH-1:0] abs_x;
      logic [COMP_WIDTH-1:0] abs_y;
      logic [COMP_WIDTH-1:0] abs_z;
      logic [COMP_WIDTH-1:0] raw_y;
      logic [COMP_WIDTH-1:0] raw_z;
   } item_type;

   function automatic logic [COMP_WIDTH-1:0] pack_signed(input logic neg,
                                                         input logic [QUOT_W-1:0] q);
      logic [REM_W-1:0] mag;
      logic [REM_W-1:0] lim;
      mag = REM_W'(q);
      lim = REM_W'(1) << (COMP_WIDTH - 1);
      if (neg) begin
         if (mag > lim) mag = lim;
         pack_signed = COMP_WIDTH'(~mag + REM_W'(1));
      end else begin
         if (mag > lim - REM_W'(1)) mag = lim - REM_W'(1);
         pack_signed = mag[COMP_WIDTH-1:0];
      end
   endfunction
endpackage

>>> hdl/vnm_front.sv
`timescale 1ns / 1ps
module vnm_front import vnm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  in_planar,
   input  logic [COMP_WIDTH-1:0] in_x,
   input  logic [COMP_WIDTH-1:0] in_y,
   input  logic [COMP_WIDTH-1:0] in_z,
   output logic                  out_valid,
   output item_type              out_item,
   output logic [SUM_W-1:0]      out_sum
);
   logic                      v1_ff, v2_ff, v3_ff;
   item_type                  item1_ff, item1_in, item2_ff, item3_ff, item3_in;
   logic [2*COMP_WIDTH-1:0]   sqx_ff, sqy_ff, sqz_ff;
   logic [SUM_W-1:0]          sum_ff, sum_in;

   always_comb begin
      item1_in        = '0;
      item1_in.planar = in_planar;
      item1_in.neg_x  = in_x[COMP_WIDTH-1];
      item1_in.neg_y  = in_y[COMP_WIDTH-1];
      item1_in.neg_z  = in_z[COMP_WIDTH-1];
      item1_in.abs_x  = in_x[COMP_WIDTH-1] ? (~in_x + COMP_WIDTH'(1)) : in_x;
      item1_in.abs_y  = in_y[COMP_WIDTH-1] ? (~in_y + COMP_WIDTH'(1)) : in_y;
      item1_in.abs_z  = in_z[COMP_WIDTH-1] ? (~in_z + COMP_WIDTH'(1)) : in_z;
      item1_in.raw_y  = in_y;
      item1_in.raw_z  = in_z;
   end

   always_comb begin
      sum_in = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      if (!item2_ff.planar) sum_in = sum_in + SUM_W'(sqz_ff);
      item3_in      = item2_ff;
      item3_in.zero = (sum_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      item1_ff <= item1_in;
      item2_ff <= item1_ff;
      sqx_ff   <= item1_ff.abs_x * item1_ff.abs_x;
      sqy_ff   <= item1_ff.abs_y * item1_ff.abs_y;
      sqz_ff   <= item1_ff.abs_z * item1_ff.abs_z;
      item3_ff <= item3_in;
      sum_ff   <= sum_in;
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;
   assign out_sum   = sum_ff;
endmodule

>>> hdl/vnm_isqrt.sv
`timescale 1ns / 1ps
module vnm_isqrt import vnm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  item_type         in_item,
   input  logic [SUM_W-1:0] in_sum,
   output logic             out_valid,
   output item_type         out_item,
   output logic [SUM_W-1:0] out_root
);
   logic             valid_ff [ROOT_STEPS+1];
   item_type         item_ff  [ROOT_STEPS+1];
   logic [SUM_W-1:0] rest_ff  [ROOT_STEPS+1];
   logic [SUM_W-1:0] root_ff  [ROOT_STEPS+1];

   assign valid_ff[0] = in_valid;
   assign item_ff[0]  = in_item;
   assign rest_ff[0]  = in_sum;
   assign root_ff[0]  = '0;

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
      logic [SUM_W-1:0] trial, rest_in, root_in;

      always_comb begin
         trial = root_ff[k] + BIT;
         if (rest_ff[k] >= trial) begin
            rest_in = rest_ff[k] - trial;
            root_in = (root_ff[k] >> 1) + BIT;
         end else begin
            rest_in = rest_ff[k];
            root_in = root_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[k+1] <= 1'b0;
         else valid_ff[k+1] <= valid_ff[k];
         item_ff[k+1] <= item_ff[k];
         rest_ff[k+1] <= rest_in;
         root_ff[k+1] <= root_in;
      end
   end

   assign out_valid = valid_ff[ROOT_STEPS];
   assign out_item  = item_ff[ROOT_STEPS];
   assign out_root  = root_ff[ROOT_STEPS];
endmodule

>>> hdl/vnm_divide.sv
`timescale 1ns / 1ps
module vnm_divide import vnm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  item_type          in_item,
   input  logic [SUM_W-1:0]  in_root,
   output logic              out_valid,
   output item_type          out_item,
   output logic [SUM_W-1:0]  out_root,
   output logic [QUOT_W-1:0] out_qx,
   output logic [QUOT_W-1:0] out_qy,
   output logic [QUOT_W-1:0] out_qz
);
   logic              valid_ff [QUOT_W+1];
   item_type          item_ff  [QUOT_W+1];
   logic [SUM_W-1:0]  root_ff  [QUOT_W+1];
   logic [REM_W-1:0]  rx_ff    [QUOT_W+1];
   logic [REM_W-1:0]  ry_ff    [QUOT_W+1];
   logic [REM_W-1:0]  rz_ff    [QUOT_W+1];
   logic [QUOT_W-1:0] qx_ff    [QUOT_W+1];
   logic [QUOT_W-1:0] qy_ff    [QUOT_W+1];
   logic [QUOT_W-1:0] qz_ff    [QUOT_W+1];

   assign valid_ff[0] = in_valid;
   assign item_ff[0]  = in_item;
   assign root_ff[0]  = in_root;
   assign rx_ff[0]    = REM_W'(in_item.abs_x) << FRAC_BITS;
   assign ry_ff[0]    = REM_W'(in_item.abs_y) << FRAC_BITS;
   assign rz_ff[0]    = REM_W'(in_item.abs_z) << FRAC_BITS;
   assign qx_ff[0]    = '0;
   assign qy_ff[0]    = '0;
   assign qz_ff[0]    = '0;

   for (genvar g = 0; g < QUOT_W; g++) begin : g_step
      localparam int SH = QUOT_W - 1 - g;
      logic [REM_W-1:0]  dvs;
      logic [REM_W-1:0]  rx_in, ry_in, rz_in;
      logic [QUOT_W-1:0] qx_in, qy_in, qz_in;

      always_comb begin
         dvs   = REM_W'(root_ff[g][MAG_W-1:0]) << SH;
         rx_in = rx_ff[g];
         ry_in = ry_ff[g];
         rz_in = rz_ff[g];
         qx_in = qx_ff[g];
         qy_in = qy_ff[g];
         qz_in = qz_ff[g];
         if (rx_ff[g] >= dvs) begin
            rx_in     = rx_ff[g] - dvs;
            qx_in[SH] = 1'b1;
         end
         if (ry_ff[g] >= dvs) begin
            ry_in     = ry_ff[g] - dvs;
            qy_in[SH] = 1'b1;
         end
         if (rz_ff[g] >= dvs) begin
            rz_in     = rz_ff[g] - dvs;
            qz_in[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[g+1] <= 1'b0;
         else valid_ff[g+1] <= valid_ff[g];
         item_ff[g+1] <= item_ff[g];
         root_ff[g+1] <= root_ff[g];
         rx_ff[g+1]   <= rx_in;
         ry_ff[g+1]   <= ry_in;
         rz_ff[g+1]   <= rz_in;
         qx_ff[g+1]   <= qx_in;
         qy_ff[g+1]   <= qy_in;
         qz_ff[g+1]   <= qz_in;
      end
   end

   assign out_valid = valid_ff[QUOT_W];
   assign out_item  = item_ff[QUOT_W];
   assign out_root  = root_ff[QUOT_W];
   assign out_qx    = qx_ff[QUOT_W];
   assign out_qy    = qy_ff[QUOT_W];
   assign out_qz    = qz_ff[QUOT_W];
endmodule

>>> hdl/vector_normalize_with_magnitude_core.sv
// Fixed-point vector normalize: every result appears after its start beat as a one-cycle
// rsp_valid strobe that cannot be held off. A new vector is taken in every cycle and busy
// never rises. The path runs through the front end (abs, squares, sum), the square-root
// pipeline, one stage per root bit pair, the divider pipeline, one stage per quotient bit,
// and an output register.
`timescale 1ns / 1ps
`include "vector_normalize_with_magnitude_core_macros.svh"
module vector_normalize_with_magnitude_core import vnm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_action,
   input  logic [COMP_WIDTH-1:0] req_in_x,
   input  logic [COMP_WIDTH-1:0] req_in_y,
   input  logic [COMP_WIDTH-1:0] req_in_z,
   output logic                  rsp_valid,
   output logic [COMP_WIDTH-1:0] rsp_out_x,
   output logic [COMP_WIDTH-1:0] rsp_out_y,
   output logic [COMP_WIDTH-1:0] rsp_out_z,
   output logic [COMP_WIDTH-1:0] rsp_length,
   output logic                  rsp_zero_fallback
);
   logic                  f_valid, s_valid, d_valid;
   item_type              f_item, s_item, d_item;
   logic [SUM_W-1:0]      f_sum, s_root, d_root;
   logic [QUOT_W-1:0]     d_qx, d_qy, d_qz;
   logic                  valid_ff;
   logic [COMP_WIDTH-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, len_ff, len_in;
   logic                  zero_ff;

   assign busy = 1'b0;

   vnm_front u_front (
      .clock(clock), .reset(reset), .in_valid(start && !busy), .in_planar(req_action),
      .in_x(req_in_x), .in_y(req_in_y), .in_z(req_in_z),
      .out_valid(f_valid), .out_item(f_item), .out_sum(f_sum));

   vnm_isqrt u_isqrt (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_item(f_item),
      .in_sum(f_sum), .out_valid(s_valid), .out_item(s_item), .out_root(s_root));

   vnm_divide u_divide (
      .clock(clock), .reset(reset), .in_valid(s_valid), .in_item(s_item),
      .in_root(s_root), .out_valid(d_valid), .out_item(d_item), .out_root(d_root),
      .out_qx(d_qx), .out_qy(d_qy), .out_qz(d_qz));

   always_comb begin
      if (d_item.zero) begin
         x_in   = ONE_SIGNED;
         y_in   = d_item.raw_y;
         z_in   = d_item.raw_z;
         len_in = ONE_LEN;
      end else begin
         x_in   = pack_signed(d_item.neg_x, d_qx);
         y_in   = pack_signed(d_item.neg_y, d_qy);
         z_in   = d_item.planar ? d_item.raw_z : pack_signed(d_item.neg_z, d_qz);
         len_in = (d_root > SUM_W'({COMP_WIDTH{1'b1}})) ? {COMP_WIDTH{1'b1}}
                                                       : d_root[COMP_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= d_valid;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      len_ff  <= len_in;
      zero_ff <= d_item.zero;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_x         = x_ff;
   assign rsp_out_y         = y_ff;
   assign rsp_out_z         = z_ff;
   assign rsp_length        = len_ff;
   assign rsp_zero_fallback = zero_ff;

   `VNM_ASSERT_SAME(a_rsp_from_start, clock, reset, rsp_valid, $past(start, LATENCY))
   `VNM_ASSERT_SAME(a_zero_len_one, clock, reset, rsp_valid && rsp_zero_fallback,
                    rsp_length == ONE_LEN)
   `VNM_ASSERT_SAME(a_len_nonzero, clock, reset, rsp_valid && !rsp_zero_fallback,
                    rsp_length != '0)
endmodule
